### rtl/palloc_pkg.sv
package palloc_pkg;

	// Default geometry of the page store
	localparam int PAGE_COUNT_DEF = 32;
	localparam int PAGE_KB_DEF    = 4;
	localparam int ID_BITS_DEF    = 8;

	// Fixed field widths of the request and result
	localparam int SIZE_W  = 16;
	localparam int PID_W   = 8;
	localparam int FIELD_W = 6;

	// Width of the microcode step counter
	localparam int UPC_W = 3;

	// Request function codes; the fourth code acts as a query
	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_QUERY = 2'd2
	} palloc_func_e;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_NOMEM  = 2'd2,
		ST_ABSENT = 2'd3
	} palloc_status_e;

	// Jump conditions of the microcode
	typedef enum logic [2:0] {
		CND_NEXT       = 3'd0,
		CND_ALWAYS     = 3'd1,
		CND_WAIT_START = 3'd2,
		CND_CLR_MORE   = 3'd3,
		CND_SCAN_MORE  = 3'd4,
		CND_SKIP_WR    = 3'd5,
		CND_WR_MORE    = 3'd6
	} palloc_cond_e;

	// One control word of the microcode program
	typedef struct packed {
		logic               idle;
		logic               clr;
		logic               calc;
		logic               scan;
		logic               close;
		logic               setup;
		logic               wr;
		logic               done;
		palloc_cond_e       cond;
		logic [UPC_W-1:0]   target;
	} palloc_cw_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic clr_more;
		logic scan_more;
		logic skip_wr;
		logic wr_more;
	} palloc_flags_t;

	// Request payload
	typedef struct packed {
		logic [1:0]        func;
		logic [PID_W-1:0]  program_id;
		logic [SIZE_W-1:0] size_kb;
	} palloc_req_t;

	// Result payload
	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] pages;
		logic [FIELD_W-1:0] first_page;
		logic [FIELD_W-1:0] free_runs;
	} palloc_res_t;

endpackage

### rtl/palloc_useq.sv
module palloc_useq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  palloc_pkg::palloc_flags_t flags,
	output palloc_pkg::palloc_cw_t  cw
);
	import palloc_pkg::*;

	// Program addresses
	localparam logic [UPC_W-1:0] PC_CLR   = 3'd0;
	localparam logic [UPC_W-1:0] PC_IDLE  = 3'd1;
	localparam logic [UPC_W-1:0] PC_NEED  = 3'd2;
	localparam logic [UPC_W-1:0] PC_SCAN  = 3'd3;
	localparam logic [UPC_W-1:0] PC_CLOSE = 3'd4;
	localparam logic [UPC_W-1:0] PC_SETUP = 3'd5;
	localparam logic [UPC_W-1:0] PC_WR    = 3'd6;

	logic [UPC_W-1:0] upc_q;
	logic             jump;

	// Microcode program
	function automatic palloc_cw_t ucode_rom(input logic [UPC_W-1:0] pc);
		palloc_cw_t w;
		w = '0;
		case (pc)
			PC_CLR: begin
				w.clr    = 1'b1;
				w.cond   = CND_CLR_MORE;
				w.target = PC_CLR;
			end
			PC_IDLE: begin
				w.idle   = 1'b1;
				w.cond   = CND_WAIT_START;
				w.target = PC_IDLE;
			end
			PC_NEED: begin
				w.calc = 1'b1;
				w.cond = CND_NEXT;
			end
			PC_SCAN: begin
				w.scan   = 1'b1;
				w.cond   = CND_SCAN_MORE;
				w.target = PC_SCAN;
			end
			PC_CLOSE: begin
				w.close = 1'b1;
				w.cond  = CND_NEXT;
			end
			PC_SETUP: begin
				w.setup  = 1'b1;
				w.cond   = CND_SKIP_WR;
				w.target = PC_WR + 3'd1;
			end
			PC_WR: begin
				w.wr     = 1'b1;
				w.cond   = CND_WR_MORE;
				w.target = PC_WR;
			end
			default: begin
				w.done   = 1'b1;
				w.cond   = CND_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

	assign cw = ucode_rom(upc_q);

	// Select the jump condition
	always_comb begin
		case (cw.cond)
			CND_ALWAYS:     jump = 1'b1;
			CND_WAIT_START: jump = !start;
			CND_CLR_MORE:   jump = flags.clr_more;
			CND_SCAN_MORE:  jump = flags.scan_more;
			CND_SKIP_WR:    jump = flags.skip_wr;
			CND_WR_MORE:    jump = flags.wr_more;
			default:        jump = 1'b0;
		endcase
	end

	// Advance or jump the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= PC_CLR;
		end else if (jump) begin
			upc_q <= cw.target;
		end else begin
			upc_q <= upc_q + 3'd1;
		end
	end

endmodule

### rtl/palloc_dpath.sv
module palloc_dpath #(
	parameter int PAGE_COUNT = palloc_pkg::PAGE_COUNT_DEF,
	parameter int PAGE_KB    = palloc_pkg::PAGE_KB_DEF,
	parameter int ID_BITS    = palloc_pkg::ID_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  palloc_pkg::palloc_req_t   req,
	input  logic                      fit_mode,
	input  palloc_pkg::palloc_cw_t    cw,
	output palloc_pkg::palloc_flags_t flags,
	output logic                      done,
	output palloc_pkg::palloc_res_t   result
);
	import palloc_pkg::*;

	localparam int IW = $clog2(PAGE_COUNT);
	localparam int AW = $clog2(PAGE_COUNT + 1);
	localparam int CW = $clog2(PAGE_COUNT + 2);

	// Ceiling divide by the page size as a reciprocal multiply
	localparam int NUM_W = SIZE_W + 1;
	localparam int LG    = $clog2(PAGE_KB);
	localparam int SHF   = NUM_W + LG;
	localparam int MUL   = ((1 << SHF) + PAGE_KB - 1) / PAGE_KB;
	localparam int MW    = NUM_W + 2;
	localparam int PW    = NUM_W + MW;

	localparam logic [AW-1:0] LAST_A   = AW'(PAGE_COUNT - 1);
	localparam logic [AW-1:0] END_A    = AW'(PAGE_COUNT);
	localparam logic [CW-1:0] NEED_MAX = CW'(PAGE_COUNT + 1);

	// Owner map
	logic [ID_BITS-1:0] owner_mem [PAGE_COUNT];

	logic               accept;
	palloc_req_t        req_q;
	logic [ID_BITS-1:0] id_q;
	logic [PW-1:0]      prod_q;
	logic [NUM_W-1:0]   num_in;
	logic [NUM_W-1:0]   quot;
	logic [CW-1:0]      need_q;

	logic [AW-1:0]      addr_q;
	logic               vld_s1;
	logic [ID_BITS-1:0] rdata_s1;
	logic [IW-1:0]      idx_s1;

	logic               prev_free_q;
	logic [IW-1:0]      cur_start_q;
	logic [CW-1:0]      cur_len_q;
	logic [CW-1:0]      runs_q;
	logic               present_q;
	logic [CW-1:0]      freed_q;
	logic               found_q;
	logic [IW-1:0]      best_start_q;
	logic [CW-1:0]      best_len_q;
	logic [CW-1:0]      wcnt_q;
	logic               done_q;
	palloc_res_t        res_q;
	palloc_res_t        res_d;

	logic               is_alloc;
	logic               is_free;
	logic               id_nz;
	logic               alloc_ok;
	logic               page_in;
	logic               match;
	logic               kill;
	logic               pg_free;
	logic               closing;
	logic               take;
	logic               rd_en;
	logic               we;
	logic [IW-1:0]      waddr;
	logic [ID_BITS-1:0] wdata;

	assign accept   = cw.idle && start;
	assign num_in   = NUM_W'(req.size_kb) + NUM_W'(PAGE_KB - 1);
	assign quot     = NUM_W'(prod_q >> SHF);

	assign is_alloc = req_q.func == FN_ALLOC;
	assign is_free  = req_q.func == FN_FREE;
	assign id_nz    = id_q != '0;
	assign alloc_ok = is_alloc && id_nz && !present_q && found_q;

	// Classify the page coming out of the map
	assign page_in  = cw.scan && vld_s1;
	assign match    = rdata_s1 == id_q;
	assign kill     = is_free && id_nz && match;
	assign pg_free  = (rdata_s1 == '0) || kill;

	// Compare a closed free run against the best so far
	assign closing  = prev_free_q && ((page_in && !pg_free) || cw.close);
	assign take     = closing && (cur_len_q >= need_q) &&
		(!found_q || (fit_mode ? (cur_len_q > best_len_q) : (cur_len_q < best_len_q)));

	assign flags.clr_more  = addr_q != LAST_A;
	assign flags.scan_more = addr_q != END_A;
	assign flags.skip_wr   = !alloc_ok;
	assign flags.wr_more   = (wcnt_q + CW'(1)) != need_q;

	assign rd_en = cw.scan && flags.scan_more;

	// Single write port: clear sweep, allocation fill, release during scan
	always_comb begin
		we    = 1'b0;
		waddr = addr_q[IW-1:0];
		wdata = '0;
		if (cw.clr) begin
			we = 1'b1;
		end else if (cw.wr) begin
			we    = 1'b1;
			wdata = id_q;
		end else if (page_in && kill) begin
			we    = 1'b1;
			waddr = idx_s1;
		end
	end

	// Owner map write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			owner_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= owner_mem[addr_q[IW-1:0]];
			idx_s1   <= addr_q[IW-1:0];
		end
	end

	// Control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			prev_free_q <= 1'b0;
			runs_q      <= '0;
			present_q   <= 1'b0;
			freed_q     <= '0;
			found_q     <= 1'b0;
			wcnt_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			done_q <= cw.done;
			if (accept) begin
				addr_q      <= '0;
				prev_free_q <= 1'b0;
				runs_q      <= '0;
				present_q   <= 1'b0;
				freed_q     <= '0;
				found_q     <= 1'b0;
			end
			if (cw.clr || cw.wr || rd_en) begin
				addr_q <= addr_q + AW'(1);
			end
			if (cw.setup) begin
				addr_q <= AW'(best_start_q);
				wcnt_q <= '0;
			end
			if (cw.wr) begin
				wcnt_q <= wcnt_q + CW'(1);
			end
			if (page_in) begin
				prev_free_q <= pg_free;
				if (match) begin
					present_q <= 1'b1;
				end
				if (kill) begin
					freed_q <= freed_q + CW'(1);
				end
				if (pg_free && !prev_free_q) begin
					runs_q <= runs_q + CW'(1);
				end
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	// Request, page count, run tracking and result capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			id_q   <= ID_BITS'(req.program_id);
			prod_q <= PW'(num_in) * PW'(MUL);
		end
		if (cw.calc) begin
			if (quot > NUM_W'(PAGE_COUNT)) begin
				need_q <= NEED_MAX;
			end else if (quot == '0) begin
				need_q <= CW'(1);
			end else begin
				need_q <= CW'(quot);
			end
		end
		if (page_in && pg_free) begin
			if (!prev_free_q) begin
				cur_start_q <= idx_s1;
				cur_len_q   <= CW'(1);
			end else begin
				cur_len_q <= cur_len_q + CW'(1);
			end
		end
		if (take) begin
			best_start_q <= cur_start_q;
			best_len_q   <= cur_len_q;
		end
		if (cw.done) begin
			res_q <= res_d;
		end
	end

	// Build the result
	always_comb begin
		res_d            = '0;
		res_d.free_runs  = FIELD_W'(runs_q);
		if (is_alloc) begin
			if (!id_nz || present_q) begin
				res_d.status = ST_DUP;
			end else if (!found_q) begin
				res_d.status = ST_NOMEM;
			end else begin
				res_d.status     = ST_OK;
				res_d.pages      = FIELD_W'(need_q);
				res_d.first_page = FIELD_W'(CW'(best_start_q) + CW'(1));
				res_d.free_runs  = FIELD_W'(runs_q - CW'(need_q == best_len_q));
			end
		end else if (is_free) begin
			if (freed_q == '0) begin
				res_d.status = ST_ABSENT;
			end else begin
				res_d.status = ST_OK;
				res_d.pages  = FIELD_W'(freed_q);
			end
		end else begin
			res_d.status = ST_OK;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### rtl/page_allocator_best_worst_fit.sv
// Page allocator with best-fit / worst-fit placement over an owner map.
// Request channel: a request (func, program_id, size_kb) is taken at a rising
// edge with start high and busy low. Functions: allocate, free, query.
// Result channel: done strobes for one cycle with status, pages, first_page and
// free_runs; the receiver cannot stall it, so it must take every strobe.
// Config channel: cfg_valid/cfg_ready write fit_mode (0 best fit, 1 worst fit);
// cfg_ready is always high, write it only while no request is in flight.
// Timing: a request walks the microcode program in order: one step computes
// the page count, the owner map scan reads one page per cycle through its
// single registered read port, then come a close and a branch step, write
// steps that fill the pages of a successful allocate, and one result step.
// done rises the cycle after the result step, and busy is already low then,
// so the next request can be taken at the same edge that takes the result.
// Reset: fit_mode returns to best fit and a clearing pass writes every page
// free, one page a cycle, with busy high throughout.
module page_allocator_best_worst_fit #(
	parameter int PAGE_COUNT = palloc_pkg::PAGE_COUNT_DEF,
	parameter int PAGE_KB    = palloc_pkg::PAGE_KB_DEF,
	parameter int ID_BITS    = palloc_pkg::ID_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  palloc_pkg::palloc_req_t req,
	output logic                    done,
	output palloc_pkg::palloc_res_t result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data
);
	import palloc_pkg::*;

	palloc_cw_t    cw;
	palloc_flags_t flags;
	logic          fit_mode_q;

	assign cfg_ready = 1'b1;
	assign busy      = !cw.idle;

	// Hold the placement mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			fit_mode_q <= cfg_data;
		end
	end

	palloc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cw     (cw)
	);

	palloc_dpath #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_KB    (PAGE_KB),
		.ID_BITS    (ID_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.fit_mode (fit_mode_q),
		.cw       (cw),
		.flags    (flags),
		.done     (done),
		.result   (result)
	);

endmodule

### rtl/palloc_chk.sv
module palloc_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input palloc_pkg::palloc_res_t result
);
	import palloc_pkg::*;

	// A result only shows once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request occupies the block next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// No result right after acceptance
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result one cycle after request");

	// Strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// Failed results carry no allocation
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |->
		(result.pages == '0 && result.first_page == '0))
		else $error("error result reports pages");

endmodule

bind page_allocator_best_worst_fit palloc_chk u_palloc_chk (.*);
